FILE: rtl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and the byte encoder for the UTF-16 to UTF-8 unit.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [5:0]  HIGH_TAG   = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0]  LOW_TAG    = 6'b110111;  // 0xDC00..0xDFFF
  localparam logic [15:0] SURR_BASE  = 16'hD800;
  localparam logic [20:0] PLANE_BASE = 21'h10000;
  localparam logic [7:0]  CONT_MARK  = 8'h80;
  localparam logic [7:0]  LEAD2_MARK = 8'hC0;
  localparam logic [7:0]  LEAD3_MARK = 8'hE0;
  localparam logic [7:0]  LEAD4_MARK = 8'hF0;

  localparam logic [2:0] LEN1 = 3'd1;
  localparam logic [2:0] LEN2 = 3'd2;
  localparam logic [2:0] LEN3 = 3'd3;
  localparam logic [2:0] LEN4 = 3'd4;

  // one queue entry: an optional flushed high surrogate, then an optional code point
  typedef struct packed {
    logic        flush;
    logic [9:0]  flush_bits;
    logic        main;
    logic [20:0] point;
    logic [2:0]  len;
    logic        last;
  } cmd_t;

  // byte number idx of the utf-8 form of point, which is len bytes long
  function automatic logic [7:0] enc_byte(input logic [20:0] point, input logic [2:0] len,
                                          input logic [1:0] idx);
    logic [7:0] b;
    b = CONT_MARK | {2'b00, point[5:0]};
    unique case (len)
      LEN1: b = {1'b0, point[6:0]};
      LEN2: begin
        if (idx == 2'd0) b = LEAD2_MARK | {3'b000, point[10:6]};
      end
      LEN3: begin
        if (idx == 2'd0) b = LEAD3_MARK | {4'b0000, point[15:12]};
        else if (idx == 2'd1) b = CONT_MARK | {2'b00, point[11:6]};
      end
      LEN4: begin
        if (idx == 2'd0) b = LEAD4_MARK | {5'b00000, point[20:18]};
        else if (idx == 2'd1) b = CONT_MARK | {2'b00, point[17:12]};
        else if (idx == 2'd2) b = CONT_MARK | {2'b00, point[11:6]};
      end
      default: b = CONT_MARK | {2'b00, point[5:0]};
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/utf16_to_utf8_stream_unit.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_stream_unit
// Streaming UTF-16 to UTF-8 transcoder, one output byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// the first byte of a unit passes through the command queue and then the output register
// throughput: one byte per cycle from the sequencer while the output is not stalled, so a
//   unit yields one to six bytes (three for a typical three-byte unit); a held high surrogate yields none
// the front takes a unit every cycle while the command queue has room
// reset: synchronous, clears the held surrogate, the queue and the output valid
module utf16_to_utf8_stream_unit #(
  parameter int QueueDepth = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] code_unit,
  input  logic        end_of_text,
  input  logic        unit_valid,
  output logic        unit_stall,
  output logic [7:0]  utf8_byte,
  output logic        run_last,
  output logic        text_last,
  output logic        byte_valid,
  input  logic        byte_stall
);
  import u16u8_pkg::*;

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  u16u8_front front (
    .clk         (clk),
    .rst         (rst),
    .code_unit   (code_unit),
    .end_of_text (end_of_text),
    .unit_valid  (unit_valid),
    .unit_stall  (unit_stall),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  u16u8_queue #(.Depth(QueueDepth)) queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  u16u8_back back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .utf8_byte  (utf8_byte),
    .run_last   (run_last),
    .text_last  (text_last),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall)
  );

endmodule

FILE: rtl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates and builds at most one command per unit.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        code_unit,
  input  logic               end_of_text,
  input  logic               unit_valid,
  output logic               unit_stall,
  input  logic               q_full,
  output logic               push,
  output u16u8_pkg::cmd_t    push_cmd
);
  import u16u8_pkg::*;

  logic       held_valid;
  logic [9:0] held_high_bits;
  logic       held_valid_next;
  logic       accept;
  logic       is_high;
  logic       is_low;

  assign unit_stall = q_full;
  assign accept     = unit_valid && !q_full;
  assign is_high    = code_unit[15:10] == HIGH_TAG;
  assign is_low     = code_unit[15:10] == LOW_TAG;

  always_comb begin
    push_cmd            = '0;
    push_cmd.last       = end_of_text;
    push_cmd.flush_bits = held_high_bits;
    held_valid_next     = 1'b0;
    if (held_valid && is_low) begin
      push_cmd.main  = 1'b1;
      push_cmd.point = PLANE_BASE + {1'b0, held_high_bits, code_unit[9:0]};
      push_cmd.len   = LEN4;
    end else begin
      push_cmd.flush = held_valid;
      if (is_high && !end_of_text) begin
        held_valid_next = 1'b1;
      end else begin
        push_cmd.main  = 1'b1;
        push_cmd.point = {5'b00000, code_unit};
        if (code_unit[15:7] == '0) push_cmd.len = LEN1;
        else if (code_unit[15:11] == '0) push_cmd.len = LEN2;
        else push_cmd.len = LEN3;
      end
    end
  end

  // a unit that is only held produces nothing yet
  assign push = accept && (push_cmd.flush || push_cmd.main);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid     <= 1'b0;
      held_high_bits <= '0;
    end else if (accept) begin
      held_valid <= held_valid_next;
      if (is_high) held_high_bits <= code_unit[9:0];
    end
  end

endmodule

FILE: rtl/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// Small command fifo between the front and the byte sequencer.
// ----------------------------------------------------------------------------
module u16u8_queue #(
  parameter int Depth = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u16u8_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output u16u8_pkg::cmd_t head
);
  import u16u8_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = count == CntW'(Depth);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: rtl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Walks the head command one byte per cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  u16u8_pkg::cmd_t head,
  output logic            pop,
  output logic [7:0]      utf8_byte,
  output logic            run_last,
  output logic            text_last,
  output logic            byte_valid,
  input  logic            byte_stall
);
  import u16u8_pkg::*;

  logic [2:0] pos;
  logic [2:0] total;
  logic [2:0] main_pos;
  logic       load;
  logic       at_end;
  logic [7:0] cur_byte;

  assign total    = (head.flush ? 3'd3 : 3'd0) + (head.main ? head.len : 3'd0);
  assign main_pos = pos - (head.flush ? 3'd3 : 3'd0);
  assign at_end   = pos == total - 3'd1;
  assign load     = !q_empty && (!byte_valid || !byte_stall);
  assign pop      = load && at_end;

  // flushed high surrogate is always three bytes, ahead of the main point
  always_comb begin
    if (head.flush && pos < 3'd3) begin
      cur_byte = enc_byte({5'b00000, SURR_BASE | {6'b000000, head.flush_bits}}, LEN3,
                          pos[1:0]);
    end else begin
      cur_byte = enc_byte(head.point, head.len, main_pos[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      byte_valid <= 1'b0;
    end else begin
      if (load) pos <= at_end ? 3'd0 : pos + 3'd1;
      if (load) byte_valid <= 1'b1;
      else if (!byte_stall) byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      utf8_byte <= cur_byte;
      run_last  <= at_end;
      text_last <= at_end && head.last;
    end
  end

endmodule

FILE: rtl/u16u8_checker.sv
// ----------------------------------------------------------------------------
// u16u8_checker
// Port-level checks for the UTF-16 to UTF-8 unit, bound to the top level.
// ----------------------------------------------------------------------------
module u16u8_checker (
  input logic        clk,
  input logic        rst,
  input logic [15:0] code_unit,
  input logic        end_of_text,
  input logic        unit_valid,
  input logic        unit_stall,
  input logic [7:0]  utf8_byte,
  input logic        run_last,
  input logic        text_last,
  input logic        byte_valid,
  input logic        byte_stall
);

  // stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    unit_valid && unit_stall |=> unit_valid && $stable(code_unit) && $stable(end_of_text))
    else $error("input item changed while stalled");

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(utf8_byte) && $stable(run_last)
      && $stable(text_last))
    else $error("output item changed while stalled");

  a_text_in_run: assert property (@(posedge clk) disable iff (rst)
    byte_valid && text_last |-> run_last)
    else $error("end of text not on the last byte of a run");

  // inside a run every byte but the last belongs to a multibyte sequence
  a_mid_run_multibyte: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !run_last |-> utf8_byte[7])
    else $error("ascii byte in the middle of a run");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !byte_valid)
    else $error("output valid right after reset");

endmodule

bind utf16_to_utf8_stream_unit u16u8_checker checker_inst (
  .clk         (clk),
  .rst         (rst),
  .code_unit   (code_unit),
  .end_of_text (end_of_text),
  .unit_valid  (unit_valid),
  .unit_stall  (unit_stall),
  .utf8_byte   (utf8_byte),
  .run_last    (run_last),
  .text_last   (text_last),
  .byte_valid  (byte_valid),
  .byte_stall  (byte_stall)
);
